[hw/rtl/dmx_pkg.sv]
// Shared types, constants and helpers for the mono downmix block.
package dmx_pkg;

  localparam int NUM_CH    = 8;
  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 36;
  localparam int MAG_W     = 35;
  localparam int CNT_W     = 4;
  localparam int CH_IDX_W  = 3;
  localparam int FMT_W     = 2;
  localparam int CARRY_W   = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 4;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 4'd1;

  localparam logic [CNT_W-1:0] CH_COUNT_RESET = 4'd2;
  localparam logic [CNT_W-1:0] CH_COUNT_MAX   = 4'd8;

  typedef enum logic [FMT_W-1:0] {
    FMT_INT8  = 2'd0,
    FMT_INT16 = 2'd1,
    FMT_INT24 = 2'd2,
    FMT_INT32 = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Request into the serial divider
  typedef struct packed {
    logic                 start;
    logic [MAG_W-1:0]     dividend;
    logic [CNT_W-1:0]     divisor;
  } div_req_t;

  // Result from the serial divider
  typedef struct packed {
    logic                 done;
    logic [MAG_W-1:0]     quo;
    logic [CNT_W-1:0]     rem;
  } div_rsp_t;

  // Upper clamp limit for a sample format
  function automatic logic signed [SUM_W-1:0] fmt_hi(input fmt_t f);
    logic signed [SUM_W-1:0] v;
    unique case (f)
      FMT_INT8:  v = 36'sd127;
      FMT_INT16: v = 36'sd32767;
      FMT_INT24: v = 36'sd8388607;
      default:   v = 36'sd2147483647;
    endcase
    return v;
  endfunction

  // Lower clamp limit for a sample format
  function automatic logic signed [SUM_W-1:0] fmt_lo(input fmt_t f);
    logic signed [SUM_W-1:0] v;
    unique case (f)
      FMT_INT8:  v = -36'sd128;
      FMT_INT16: v = -36'sd32768;
      FMT_INT24: v = -36'sd8388608;
      default:   v = -36'sd2147483648;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/dmx_divider.sv]
// Restoring bit-serial divider: one quotient bit per cycle.
module dmx_divider
  import dmx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [MAG_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic [CNT_W:0]      diff;

  // trial remainder with next dividend bit shifted in
  always_comb begin
    trial = {rem, quo[MAG_W-1]};
    fits  = (trial >= {1'b0, req.divisor});
    diff  = trial - {1'b0, req.divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[MAG_W-2:0], fits};
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

[hw/rtl/pcm_downmix_to_mono_core.sv]
// Top level of the multichannel-to-mono downmix block.
//
// Input stream s_axis: one beat is one frame of eight 32-bit signed samples.
// The first channel_count of them are summed with the carry kept from the
// previous frame, divided by the count (truncating toward zero), and
// quotient plus remainder, clamped to the sample format, leaves on m_axis.
// Config channel cfg_*: index 0 channel_count, index 1 sample_format;
// write only while the block is idle. cfg_ready is always high.
// Timing: one channel is added per cycle through a single adder, then a
// serial divider produces one quotient bit per cycle.
// The effective channel count treats zero as one and above eight as
// eight. s_axis_tready is low from the input beat until output valid, so
// a new frame is taken only once the last result is in the output register.
// The result sits in an output register; the next frame is accepted while
// it waits. If the receiver stalls, the next result waits in the finish
// step until the output register is free.
// Reset: channel_count 2, sample_format int16, carry zero, no beat pending.
module pcm_downmix_to_mono_core
  import dmx_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // sample_ch0 in [31:0] up to sample_ch7 in [255:224]
  input  logic [NUM_CH*SAMPLE_W-1:0]    s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mono_sample in [31:0]
  output logic [SAMPLE_W-1:0]           m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DAT_W-1:0]          cfg_data
);

  state_t                      state;
  state_t                      state_next;
  logic [CNT_W-1:0]            channel_count;
  fmt_t                        sample_format;
  logic signed [CARRY_W-1:0]   carry;
  logic [SAMPLE_W-1:0]         samples [NUM_CH];
  logic [CNT_W-1:0]            nch;
  logic [CNT_W-1:0]            nch_eff;
  logic [CH_IDX_W-1:0]         ch_idx;
  logic signed [SUM_W-1:0]     acc;
  logic signed [SUM_W-1:0]     acc_next;
  logic                        neg;
  logic [SUM_W-1:0]            mag;
  logic                        last_ch;
  logic                        s_accept;
  logic                        out_free;
  logic                        load_out;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;
  logic signed [SUM_W-1:0]     q_s;
  logic signed [SUM_W-1:0]     r_s;
  logic signed [SUM_W-1:0]     total;
  logic signed [SUM_W-1:0]     clamped;
  logic signed [CARRY_W-1:0]   carry_next;

  assign cfg_ready = 1'b1;
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CH_COUNT_RESET;
      sample_format <= FMT_INT16;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg_data;
      end else if (cfg_index == REG_SAMPLE_FORMAT) begin
        sample_format <= fmt_t'(cfg_data[FMT_W-1:0]);
      end
    end
  end

  // effective channel count: zero acts as one, above max acts as max
  always_comb begin
    priority if (channel_count == '0) begin
      nch_eff = CNT_W'(1);
    end else if (channel_count > CH_COUNT_MAX) begin
      nch_eff = CH_COUNT_MAX;
    end else begin
      nch_eff = channel_count;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_ACCUM;
      ST_ACCUM:  if (last_ch) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input frame capture
  always_ff @(posedge clk) begin
    if (s_accept) begin
      for (int i = 0; i < NUM_CH; i++) begin
        samples[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
      end
      nch <= nch_eff;
    end
  end

  // accumulate one channel per cycle
  assign last_ch  = ({1'b0, ch_idx} == nch - 1'b1);
  assign acc_next = acc + {{(SUM_W-SAMPLE_W){samples[ch_idx][SAMPLE_W-1]}}, samples[ch_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx <= '0;
    end else if (s_accept) begin
      ch_idx <= '0;
    end else if (state == ST_ACCUM) begin
      ch_idx <= ch_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      acc <= {{(SUM_W-CARRY_W){carry[CARRY_W-1]}}, carry};
    end else if (state == ST_ACCUM) begin
      acc <= acc_next;
    end
  end

  // magnitude of the finished sum goes to the divider
  assign neg = acc_next[SUM_W-1];
  assign mag = neg ? (~acc_next + 1'b1) : acc_next;

  assign div_req.start    = (state == ST_ACCUM) && last_ch;
  assign div_req.dividend = mag[MAG_W-1:0];
  assign div_req.divisor  = nch;

  logic sign_q;
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      sign_q <= neg;
    end
  end

  dmx_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // signed quotient and remainder, sum and clamp
  always_comb begin
    q_s = sign_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    r_s = sign_q ? -$signed({{(SUM_W-CNT_W){1'b0}}, div_rsp.rem})
                 : $signed({{(SUM_W-CNT_W){1'b0}}, div_rsp.rem});
    total = q_s + r_s;
    priority if (total > fmt_hi(sample_format)) begin
      clamped = fmt_hi(sample_format);
    end else if (total < fmt_lo(sample_format)) begin
      clamped = fmt_lo(sample_format);
    end else begin
      clamped = total;
    end
    carry_next = -r_s[CARRY_W-1:0];
  end

  // carry and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      carry         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        carry         <= carry_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= clamped[SAMPLE_W-1:0];
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_axis_tready)
    else $error("input accepted while a frame is in progress");

  a_carry_range: assert property (@(posedge clk) disable iff (rst)
    carry != 4'sb1000)
    else $error("carry outside -7..7");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide step");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_axis_tvalid && state == ST_IDLE)
    else $error("finished result not presented");

endmodule
